// ===== design/matrix_saddle_point_detect_top_macros.svh =====
// ----------------------------------------------------------------------------
// Saddle point detector assertion macros
// Shared concurrent assertion forms used by the saddle point detector.
// ----------------------------------------------------------------------------
`ifndef MATRIX_SADDLE_POINT_DETECT_TOP_MACROS_SVH
`define MATRIX_SADDLE_POINT_DETECT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SADP_ASSERT_SAME(name, clk_sig, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SADP_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sadp_pkg.sv =====
// ----------------------------------------------------------------------------
// Saddle point detector package
// Sizes, types and helper functions shared by the saddle point detector.
// ----------------------------------------------------------------------------
package sadp_pkg;

  localparam int MAX_DIM     = 64;
  localparam int DIM_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ELEM_W      = 32;
  localparam int CNT_W       = 7;
  localparam int SPAN_W      = 2 * ELEM_W;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [DIM_W-1:0]         dim_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef struct packed {
    elem_t hi;
    elem_t lo;
  } span_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef enum logic [0:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic active;
    logic matrix_done;
  } load_stat_t;

  typedef struct packed {
    logic issue_last;
    logic cmp_valid;
    logic found;
  } check_stat_t;

  // Index of the last row or column in use for a programmed count.
  function automatic dim_t last_index(cnt_t v);
    dim_t res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM - 1);
    end else begin
      res = DIM_W'(v - 1'b1);
    end
    return res;
  endfunction

  function automatic span_t merge_span(span_t s, elem_t e);
    span_t res;
    res.lo = (e < s.lo) ? e : s.lo;
    res.hi = (e > s.hi) ? e : s.hi;
    return res;
  endfunction

endpackage

// ===== design/sadp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sadp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sadp_load.sv =====
// ----------------------------------------------------------------------------
// Saddle point detector load stage
// Stores each element beat and keeps running row and column extremes.
// ----------------------------------------------------------------------------
module sadp_load (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                accept,
  input  sadp_pkg::elem_t     element,
  input  sadp_pkg::dim_t      last_col,
  input  sadp_pkg::dim_t      last_row,
  output logic                elem_we,
  output sadp_pkg::addr_t     elem_waddr,
  output sadp_pkg::elem_t     elem_wdata,
  output sadp_pkg::dim_t      col_raddr,
  input  sadp_pkg::span_t     col_rdata,
  output logic                col_we,
  output sadp_pkg::dim_t      col_waddr,
  output sadp_pkg::span_t     col_wdata,
  output logic                row_we,
  output sadp_pkg::dim_t      row_waddr,
  output sadp_pkg::span_t     row_wdata,
  output sadp_pkg::load_stat_t stat
);
  import sadp_pkg::*;

  dim_t  cpos;
  dim_t  rpos;
  addr_t lpos;

  logic  s1_valid;
  elem_t s1_elem;
  dim_t  s1_col;
  dim_t  s1_row;
  logic  s1_first_row;
  logic  s1_row_end;
  logic  s1_last;

  span_t row_span;
  logic  bp_valid;
  dim_t  bp_col;
  span_t bp_span;

  span_t col_prev;
  span_t col_new;
  span_t row_new;
  logic  at_row_end;
  logic  at_last;

  assign at_row_end = (cpos == last_col);
  assign at_last    = at_row_end && (rpos == last_row);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cpos <= '0;
      rpos <= '0;
      lpos <= '0;
    end else if (accept) begin
      if (at_row_end) begin
        cpos <= '0;
        if (at_last) begin
          rpos <= '0;
          lpos <= '0;
        end else begin
          rpos <= rpos + 1'b1;
          lpos <= lpos + 1'b1;
        end
      end else begin
        cpos <= cpos + 1'b1;
        lpos <= lpos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      bp_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      bp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_elem      <= element;
      s1_col       <= cpos;
      s1_row       <= rpos;
      s1_first_row <= (rpos == '0);
      s1_row_end   <= at_row_end;
      s1_last      <= at_last;
    end
    if (s1_valid) begin
      row_span <= row_new;
    end
    bp_col  <= s1_col;
    bp_span <= col_new;
  end

  // The column entry written in the previous cycle is not yet visible at the
  // RAM output, so it is forwarded when the same column comes back.
  always_comb begin
    col_prev = (bp_valid && (bp_col == s1_col)) ? bp_span : col_rdata;
    if (s1_first_row) begin
      col_new = '{hi: s1_elem, lo: s1_elem};
    end else begin
      col_new = merge_span(col_prev, s1_elem);
    end
    if (s1_col == '0) begin
      row_new = '{hi: s1_elem, lo: s1_elem};
    end else begin
      row_new = merge_span(row_span, s1_elem);
    end
  end

  assign elem_we    = accept;
  assign elem_waddr = lpos;
  assign elem_wdata = element;
  assign col_raddr  = cpos;

  assign col_we    = s1_valid;
  assign col_waddr = s1_col;
  assign col_wdata = col_new;
  assign row_we    = s1_valid && s1_row_end;
  assign row_waddr = s1_row;
  assign row_wdata = row_new;

  assign stat.active      = s1_valid;
  assign stat.matrix_done = s1_valid && s1_last;

endmodule

// ===== design/sadp_check.sv =====
// ----------------------------------------------------------------------------
// Saddle point detector check sequencer
// Walks the stored matrix once and tests each element against its extremes.
// ----------------------------------------------------------------------------
module sadp_check (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  sadp_pkg::dim_t       last_col,
  input  sadp_pkg::dim_t       last_row,
  output sadp_pkg::addr_t      elem_raddr,
  output sadp_pkg::dim_t       row_raddr,
  output sadp_pkg::dim_t       col_raddr,
  input  sadp_pkg::elem_t      elem_rdata,
  input  sadp_pkg::span_t      row_rdata,
  input  sadp_pkg::span_t      col_rdata,
  output sadp_pkg::check_stat_t stat
);
  import sadp_pkg::*;

  logic  active;
  dim_t  kc;
  dim_t  kr;
  addr_t kidx;
  logic  cmp_valid;
  logic  found;
  logic  issue_last;
  logic  hit;

  assign issue_last = active && (kc == last_col) && (kr == last_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      kc        <= '0;
      kr        <= '0;
      kidx      <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      cmp_valid <= active;
      if (start) begin
        active <= 1'b1;
        kc     <= '0;
        kr     <= '0;
        kidx   <= '0;
        found  <= 1'b0;
      end else begin
        if (active) begin
          kidx <= kidx + 1'b1;
          if (kc == last_col) begin
            kc <= '0;
            kr <= kr + 1'b1;
            if (kr == last_row) begin
              active <= 1'b0;
            end
          end else begin
            kc <= kc + 1'b1;
          end
        end
        if (cmp_valid && hit) begin
          found <= 1'b1;
        end
      end
    end
  end

  assign hit = ((elem_rdata == row_rdata.lo) && (elem_rdata == col_rdata.hi)) ||
               ((elem_rdata == row_rdata.hi) && (elem_rdata == col_rdata.lo));

  assign elem_raddr = kidx;
  assign row_raddr  = kr;
  assign col_raddr  = kc;

  assign stat.issue_last = issue_last;
  assign stat.cmp_valid  = cmp_valid;
  assign stat.found      = found;

endmodule

// ===== design/matrix_saddle_point_detect_top.sv =====
// ----------------------------------------------------------------------------
// Matrix saddle point detector
// A matrix of R rows by C columns (set by row_count and col_count, a count
// of zero acts as one and a count above 64 as 64) arrives as R*C element
// beats in row-major order, one per cycle at most. Each beat is written to
// the element memory while row and column minimum and maximum are built on
// the fly. After the last beat, a check pass reads the element memory once
// through its single read port, one element per cycle, so element_stall
// stays high until the check pass is over and the output register is free
// for the new result. The one-bit result waits in an output register
// while the next matrix loads. Writing either count register restarts the
// matrix being loaded. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "matrix_saddle_point_detect_top_macros.svh"

module matrix_saddle_point_detect_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [sadp_pkg::CNT_W-1:0] cfg_data,
  input  logic                  element_valid,
  output logic                  element_stall,
  input  logic signed [sadp_pkg::ELEM_W-1:0] element_value,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  saddle_found
);
  import sadp_pkg::*;

  state_t      state;
  state_t      state_next;
  cnt_t        row_count;
  cnt_t        col_count;
  dim_t        last_col;
  dim_t        last_row;
  logic        cfg_hit;
  logic        accept;
  logic        check_start;
  logic        emit;

  load_stat_t  ld_stat;
  check_stat_t chk_stat;

  logic        elem_we;
  addr_t       elem_waddr;
  elem_t       elem_wdata;
  addr_t       elem_raddr;
  logic [ELEM_W-1:0] elem_rdata_raw;

  dim_t        ld_col_raddr;
  dim_t        chk_col_raddr;
  dim_t        col_raddr;
  logic        col_we;
  dim_t        col_waddr;
  span_t       col_wdata;
  logic [SPAN_W-1:0] col_rdata_raw;

  logic        row_we;
  dim_t        row_waddr;
  span_t       row_wdata;
  dim_t        row_raddr;
  logic [SPAN_W-1:0] row_rdata_raw;

  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_ROW_COUNT: cfg_hit = cfg_we;
      REG_COL_COUNT: cfg_hit = cfg_we;
      default:       cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CNT_W'(1);
      col_count <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_COL_COUNT: col_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign last_row = last_index(row_count);
  assign last_col = last_index(col_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (ld_stat.matrix_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_stat.issue_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!chk_stat.cmp_valid && (!result_valid || !result_stall)) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    element_stall = 1'b1;
    check_start   = 1'b0;
    emit          = 1'b0;
    case (state)
      ST_LOAD: begin
        element_stall = ld_stat.matrix_done;
        check_start   = ld_stat.matrix_done;
      end
      ST_CHECK: begin
        element_stall = 1'b1;
      end
      ST_FINISH: begin
        emit = !chk_stat.cmp_valid && (!result_valid || !result_stall);
      end
      default: element_stall = 1'b1;
    endcase
  end

  assign accept = element_valid && !element_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      saddle_found <= chk_stat.found;
    end
  end

  sadp_load u_load (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_hit),
    .accept     (accept),
    .element    (element_value),
    .last_col   (last_col),
    .last_row   (last_row),
    .elem_we    (elem_we),
    .elem_waddr (elem_waddr),
    .elem_wdata (elem_wdata),
    .col_raddr  (ld_col_raddr),
    .col_rdata  (span_t'(col_rdata_raw)),
    .col_we     (col_we),
    .col_waddr  (col_waddr),
    .col_wdata  (col_wdata),
    .row_we     (row_we),
    .row_waddr  (row_waddr),
    .row_wdata  (row_wdata),
    .stat       (ld_stat)
  );

  sadp_check u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (check_start),
    .last_col   (last_col),
    .last_row   (last_row),
    .elem_raddr (elem_raddr),
    .row_raddr  (row_raddr),
    .col_raddr  (chk_col_raddr),
    .elem_rdata (elem_t'(elem_rdata_raw)),
    .row_rdata  (span_t'(row_rdata_raw)),
    .col_rdata  (span_t'(col_rdata_raw)),
    .stat       (chk_stat)
  );

  assign col_raddr = (state == ST_CHECK) ? chk_col_raddr : ld_col_raddr;

  sadp_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (STORE_DEPTH)
  ) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .raddr (elem_raddr),
    .rdata (elem_rdata_raw)
  );

  sadp_ram #(
    .WIDTH (SPAN_W),
    .DEPTH (MAX_DIM)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata_raw)
  );

  sadp_ram #(
    .WIDTH (SPAN_W),
    .DEPTH (MAX_DIM)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .raddr (col_raddr),
    .rdata (col_rdata_raw)
  );

  `SADP_ASSERT_SAME(a_accept_in_load, clk, rst, accept, state == ST_LOAD, "element beat taken outside load")
  `SADP_ASSERT_SAME(a_check_load_idle, clk, rst, state == ST_CHECK, !ld_stat.active, "load stage busy during check pass")
  `SADP_ASSERT_SAME(a_result_after_finish, clk, rst, $rose(result_valid), $past(state) == ST_FINISH, "result appeared without a finished check")

endmodule

// ===== verif/tb_matrix_saddle_point_detect_top.sv =====
// ----------------------------------------------------------------------------
// Saddle point detector testbench
// Loads signed matrices of many shapes into the detector, row by row, and
// predicts each saddle flag from its own copy of the loaded elements. It
// covers the size limits, restarts on count writes, planted saddle points,
// ties and wide random data, under several patterns of sender and receiver
// idling.
// ----------------------------------------------------------------------------
module tb_matrix_saddle_point_detect_top;
  import sadp_pkg::*;

  typedef enum int {
    FILL_WIDE,
    FILL_NARROW,
    FILL_ROW_LOW,
    FILL_ROW_HIGH
  } fill_mode_t;

  localparam int DRAIN_CYCLES = 16;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [0:0]              cfg_index;
  cnt_t                    cfg_data;
  logic                    element_valid;
  logic                    element_stall;
  elem_t                   element_value;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic                    saddle_found;

  int                      send_idle_pct;
  int                      recv_stall_pct;
  int                      error_count;
  int                      elem_sent;
  int                      matrix_count;
  int                      flags_checked;
  int                      flags_set;

  cnt_t                    rows_cfg;
  cnt_t                    cols_cfg;
  int                      load_pos;
  elem_t                   loaded_elems [0:STORE_DEPTH-1];
  elem_t                   matrix_buf [0:STORE_DEPTH-1];
  logic                    saddle_flags_q [$];

  matrix_saddle_point_detect_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .element_valid (element_valid),
    .element_stall (element_stall),
    .element_value (element_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .saddle_found  (saddle_found)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * 1000000);
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 50) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  function automatic int dim_of(input cnt_t v);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > MAX_DIM) begin
      return MAX_DIM;
    end
    return int'(v);
  endfunction

  function automatic logic predict_saddle(input int nr, input int nc);
    elem_t row_lo [0:MAX_DIM-1];
    elem_t row_hi [0:MAX_DIM-1];
    elem_t col_lo [0:MAX_DIM-1];
    elem_t col_hi [0:MAX_DIM-1];
    elem_t v;
    for (int r = 0; r < nr; r++) begin
      row_lo[r] = 32'sh7fffffff;
      row_hi[r] = 32'sh80000000;
    end
    for (int c = 0; c < nc; c++) begin
      col_lo[c] = 32'sh7fffffff;
      col_hi[c] = 32'sh80000000;
    end
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        v = loaded_elems[r * nc + c];
        if (v < row_lo[r]) row_lo[r] = v;
        if (v > row_hi[r]) row_hi[r] = v;
        if (v < col_lo[c]) col_lo[c] = v;
        if (v > col_hi[c]) col_hi[c] = v;
      end
    end
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        v = loaded_elems[r * nc + c];
        if ((v == row_lo[r] && v == col_hi[c]) || (v == row_hi[r] && v == col_lo[c])) begin
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void absorb_element(input elem_t v);
    int nr;
    int nc;
    nr = dim_of(rows_cfg);
    nc = dim_of(cols_cfg);
    if (load_pos >= nr * nc) begin
      load_pos = 0;
    end
    loaded_elems[load_pos] = v;
    load_pos++;
    if (load_pos == nr * nc) begin
      load_pos = 0;
      matrix_count++;
      saddle_flags_q.push_back(predict_saddle(nr, nc));
    end
  endfunction

  task automatic send_element(input elem_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      element_valid <= 1'b0;
      @(posedge clk);
    end
    element_valid <= 1'b1;
    element_value <= v;
    @(posedge clk);
    while (element_stall) @(posedge clk);
    absorb_element(v);
    elem_sent++;
  endtask

  task automatic write_count(input cfg_reg_t which, input int value);
    element_valid <= 1'b0;
    while (saddle_flags_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= cnt_t'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == REG_ROW_COUNT) begin
      rows_cfg = cnt_t'(value);
    end else begin
      cols_cfg = cnt_t'(value);
    end
    load_pos = 0;
  endtask

  task automatic set_shape(input int row_raw, input int col_raw);
    write_count(REG_ROW_COUNT, row_raw);
    write_count(REG_COL_COUNT, col_raw);
  endtask

  task automatic set_idling(input int s_pct, input int r_pct);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
  endtask

  task automatic build_matrix(input int nr, input int nc, input fill_mode_t mode);
    int pr;
    int pc;
    elem_t pivot;
    for (int i = 0; i < nr * nc; i++) begin
      if (mode == FILL_NARROW) begin
        matrix_buf[i] = elem_t'($urandom_range(4)) - 2;
      end else begin
        matrix_buf[i] = elem_t'($urandom);
      end
    end
    if (mode == FILL_ROW_LOW || mode == FILL_ROW_HIGH) begin
      pr = $urandom_range(nr - 1);
      pc = $urandom_range(nc - 1);
      pivot = elem_t'($urandom_range(32'h7fffffff)) - 32'sh40000000;
      for (int c = 0; c < nc; c++) begin
        if (mode == FILL_ROW_LOW) begin
          matrix_buf[pr * nc + c] = pivot + elem_t'($urandom_range(32'h1fffffff));
        end else begin
          matrix_buf[pr * nc + c] = pivot - elem_t'($urandom_range(32'h1fffffff));
        end
      end
      for (int r = 0; r < nr; r++) begin
        if (mode == FILL_ROW_LOW) begin
          matrix_buf[r * nc + pc] = pivot - elem_t'($urandom_range(32'h1fffffff));
        end else begin
          matrix_buf[r * nc + pc] = pivot + elem_t'($urandom_range(32'h1fffffff));
        end
      end
      matrix_buf[pr * nc + pc] = pivot;
    end
  endtask

  task automatic send_buffer(input int count);
    for (int i = 0; i < count; i++) begin
      send_element(matrix_buf[i]);
    end
  endtask

  task automatic test_unit_matrix;
    send_element(32'sh80000000);
    send_element(32'sh7fffffff);
    send_element(32'sh00000000);
    send_element(32'shffffffff);
  endtask

  task automatic test_small_shapes;
    set_shape(2, 2);
    send_element(1);
    send_element(2);
    send_element(2);
    send_element(1);
    send_element(32'sh80000000);
    send_element(32'sh7fffffff);
    send_element(32'sh7fffffff);
    send_element(32'sh80000000);
    send_element(-1);
    send_element(0);
    send_element(1);
    send_element(2);
    set_shape(1, 3);
    send_element(-3);
    send_element(5);
    send_element(5);
  endtask

  task automatic test_count_limits;
    set_shape(0, 0);
    send_element(32'sh55555555);
    send_element(32'shaaaaaaaa);
    set_shape(127, 1);
    build_matrix(64, 1, FILL_WIDE);
    send_buffer(64);
    set_shape(1, 65);
    build_matrix(1, 64, FILL_ROW_HIGH);
    send_buffer(64);
  endtask

  task automatic test_restart_on_write;
    set_shape(3, 3);
    build_matrix(3, 3, FILL_WIDE);
    send_buffer(5);
    write_count(REG_ROW_COUNT, 3);
    build_matrix(3, 3, FILL_ROW_LOW);
    send_buffer(9);
    build_matrix(3, 3, FILL_NARROW);
    send_buffer(8);
    write_count(REG_COL_COUNT, 3);
    build_matrix(3, 3, FILL_ROW_HIGH);
    send_buffer(9);
  endtask

  task automatic test_large_shapes;
    set_shape(64, 6);
    build_matrix(64, 6, FILL_WIDE);
    send_buffer(64 * 6);
    set_shape(6, 64);
    build_matrix(6, 64, FILL_ROW_LOW);
    send_buffer(6 * 64);
  endtask

  task automatic test_random_matrices(input int quota);
    int start;
    int pick;
    int row_raw;
    int col_raw;
    int nr;
    int nc;
    int part;
    start = elem_sent;
    while (elem_sent - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        row_raw = $urandom_range(65, 127);
        col_raw = 1;
        if ($urandom_range(1)) begin
          col_raw = row_raw;
          row_raw = 1;
        end
      end else if (pick < 8) begin
        row_raw = $urandom_range(1) ? 0 : $urandom_range(1, 6);
        col_raw = (row_raw == 0) ? $urandom_range(6) : 0;
      end else if (pick < 85) begin
        row_raw = $urandom_range(1, 6);
        col_raw = $urandom_range(1, 6);
      end else begin
        row_raw = $urandom_range(1, 12);
        col_raw = $urandom_range(1, 12);
      end
      set_shape(row_raw, col_raw);
      nr = dim_of(cnt_t'(row_raw));
      nc = dim_of(cnt_t'(col_raw));
      repeat ($urandom_range(1, 4)) begin
        build_matrix(nr, nc, fill_mode_t'($urandom_range(3)));
        if (nr * nc > 1 && $urandom_range(99) < 8) begin
          part = $urandom_range(1, nr * nc - 1);
          send_buffer(part);
          if ($urandom_range(1)) begin
            write_count(REG_ROW_COUNT, row_raw);
          end else begin
            write_count(REG_COL_COUNT, col_raw);
          end
        end
        send_buffer(nr * nc);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic flag_exp;
    if (!rst && result_valid && !result_stall) begin
      if (saddle_flags_q.size() == 0) begin
        report_mismatch($sformatf("unexpected flag beat, saddle_found=%0b", saddle_found));
      end else begin
        flag_exp = saddle_flags_q.pop_front();
        flags_checked++;
        if (flag_exp) flags_set++;
        if (saddle_found !== flag_exp) begin
          report_mismatch($sformatf("saddle_found=%0b, predicted %0b", saddle_found, flag_exp));
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_ROW_COUNT;
    cfg_data      = '0;
    element_valid = 1'b0;
    element_value = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count   = 0;
    elem_sent     = 0;
    matrix_count  = 0;
    flags_checked = 0;
    flags_set     = 0;
    rows_cfg      = 7'd1;
    cols_cfg      = 7'd1;
    load_pos      = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_idling(9, 9);
    test_unit_matrix();
    test_small_shapes();
    test_count_limits();
    test_restart_on_write();
    set_idling(0, 0);
    test_large_shapes();

    set_idling(0, 0);
    test_random_matrices(150);
    set_idling(79, 0);
    test_random_matrices(150);
    set_idling(0, 79);
    test_random_matrices(150);
    set_idling(9, 9);
    test_random_matrices(150);

    element_valid <= 1'b0;
    while (saddle_flags_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("tb: %0d element beats loaded as %0d matrices, up to 64 rows or 64 columns",
             elem_sent, matrix_count);
    $display("tb: %0d flags checked, %0d of them set, %0d mismatches",
             flags_checked, flags_set, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
